// ===== rtl/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, widths and constants of the dual duty hill climb tracker.
// ----------------------------------------------------------------------------
package hcc_pkg;

  localparam int unsigned DUTY_WINDOW    = 50;
  localparam int unsigned STEP_WINDOW    = 10;
  localparam int unsigned STABLE_RUN_LEN = 50;

  localparam int unsigned DUTY_W  = 17;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned POWER_W = 32;
  localparam int unsigned CMP_W   = 16;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [DUTY_W-1:0] Q16_ONE = DUTY_W'(65536);
  localparam int unsigned STEP_INIT_I = 6553600;
  localparam logic signed [STEP_W-1:0] STEP_INIT = STEP_W'(STEP_INIT_I);

  // running sum widths
  localparam int unsigned DSUM_W = $clog2(DUTY_WINDOW * 65536 + 1);
  localparam int unsigned SSUM_W = $clog2(STEP_WINDOW * STEP_INIT_I + 1) + 1;
  localparam logic signed [SSUM_W-1:0] SSUM_INIT = SSUM_W'(STEP_WINDOW * STEP_INIT_I);
  localparam int unsigned RUN_W  = $clog2(STABLE_RUN_LEN + 1);
  localparam logic [RUN_W-1:0] RUN_LEN = RUN_W'(STABLE_RUN_LEN);

  // floor(sum / DUTY_WINDOW) by reciprocal multiply, exact over the sum range
  localparam int unsigned DW_LOG      = $clog2(DUTY_WINDOW);
  localparam int unsigned RECIP_SHIFT = DSUM_W + DW_LOG;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + DUTY_WINDOW - 1) / DUTY_WINDOW;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam int unsigned PROD_W = DSUM_W + RECIP_W;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_CARRIER = 2'd1,
    CFG_STEP    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DUTY_W-1:0] a;
    logic [DUTY_W-1:0] b;
  } duty_pair_t;

endpackage

// ===== rtl/dual_duty_hill_climb_tracker_core.sv =====
// ----------------------------------------------------------------------------
// dual_duty_hill_climb_tracker_core
// Two-channel perturb-and-observe duty tracker with lock-and-average.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one averaged power value per
//   control tick. Output channel (out_valid_o/out_ready_i) returns one
//   transaction per tick: both compare values, both duties and the lock flag.
//   Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 enable, 1 carrier_max, 2 step_size); write only while idle.
// Pipeline: the state registers update at the edge that accepts a tick; the
//   duty * carrier_max product is registered into the output register when
//   the output stage advances (out_ready_i high or the register empty).
// Throughput: one tick per cycle when the output is not stalled, except for
//   the tick right after the lock tick, which waits for the duty-average
//   quotient register, fed by the reciprocal multiplier from the duty sums.
// Windows are shift lines: duty cells move per climbing tick, step cells per
//   climb of their channel; running sums track them, so none is re-summed.
// Reset: all duties zero, directions up, channel one first, step windows
//   filled with 100.0 (Q16), unlocked, enable 0, carrier_max 500,
//   step_size 3277. Usable as soon as reset is released.
// Stall: when out_ready_i is low the result stays in the output register;
//   one more tick is still taken, then in_ready_o drops until it drains.
// ----------------------------------------------------------------------------
module dual_duty_hill_climb_tracker_core
  import hcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CIDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [POWER_W-1:0]  power_avg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CMP_W-1:0]    compare_a_o,
  output logic [CMP_W-1:0]    compare_b_o,
  output logic [DUTY_W-1:0]   duty_a_out_o,
  output logic [DUTY_W-1:0]   duty_b_out_o,
  output logic                locked_o
);

  // configuration
  logic                enable_q;
  logic [CMP_W-1:0]    carrier_q;
  logic [DUTY_W-1:0]   step_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      carrier_q   <= CMP_W'(500);
      step_size_q <= DUTY_W'(3277);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:  enable_q    <= cfg_wdata_i[0];
        CFG_CARRIER: carrier_q   <= cfg_wdata_i[CMP_W-1:0];
        CFG_STEP:    step_size_q <= cfg_wdata_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // tracker state
  logic [DUTY_W-1:0]        duty_a_q, duty_b_q;
  logic                     dir_a_q, dir_b_q;
  logic                     turn_b_q;
  logic [POWER_W-1:0]       last_power_q;
  logic signed [SSUM_W-1:0] ssum_a_q, ssum_b_q;
  logic [DSUM_W-1:0]        dsum_a_q, dsum_b_q;
  logic [RUN_W-1:0]         run_q;
  logic                     locked_q;
  logic [DUTY_W-1:0]        quot_a_q, quot_b_q;
  logic                     quot_ok_q;

  // pipeline control
  logic s1_valid_q, out_valid_q;
  logic advance, in_fire, climb, hold;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = (!s1_valid_q || advance) && (!locked_q || quot_ok_q);
  assign in_fire    = in_valid_i && in_ready_o;
  assign climb      = in_fire && enable_q && !locked_q;
  assign hold       = in_fire && enable_q && locked_q;

  // active channel step
  logic                     fell, dir_act;
  logic [DUTY_W-1:0]        duty_act, duty_clamp, duty_a_nxt, duty_b_nxt;
  logic signed [STEP_W-1:0] step_s, delta;
  logic signed [DUTY_W+1:0] duty_sum;

  assign fell     = power_avg_i < last_power_q;
  assign dir_act  = turn_b_q ? dir_b_q : dir_a_q;
  assign duty_act = turn_b_q ? duty_b_q : duty_a_q;
  assign step_s   = {{(STEP_W-DUTY_W){1'b0}}, step_size_q};
  assign delta    = dir_act ? -step_s : step_s;
  assign duty_sum = $signed({2'b00, duty_act}) + $signed(delta[DUTY_W+1:0]);

  always_comb begin
    if (duty_sum[DUTY_W+1]) begin
      duty_clamp = '0;
    end else if (duty_sum > $signed({2'b00, Q16_ONE})) begin
      duty_clamp = Q16_ONE;
    end else begin
      duty_clamp = duty_sum[DUTY_W-1:0];
    end
  end

  assign duty_a_nxt = turn_b_q ? duty_a_q : duty_clamp;
  assign duty_b_nxt = turn_b_q ? duty_clamp : duty_b_q;

  // window shift lines
  duty_pair_t               dwin [DUTY_WINDOW];
  duty_pair_t               dnew;
  logic signed [STEP_W-1:0] swin_a [STEP_WINDOW];
  logic signed [STEP_W-1:0] swin_b [STEP_WINDOW];
  logic                     shift_a, shift_b;

  assign dnew.a  = duty_a_nxt;
  assign dnew.b  = duty_b_nxt;
  assign shift_a = climb && !turn_b_q;
  assign shift_b = climb && turn_b_q;

  for (genvar i = 0; i < DUTY_WINDOW; i++) begin : g_dcell
    hcc_duty_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (climb),
      .d_i     ((i == 0) ? dnew : dwin[(i == 0) ? 0 : i-1]),
      .q_o     (dwin[i])
    );
  end

  for (genvar i = 0; i < STEP_WINDOW; i++) begin : g_scell
    hcc_step_cell u_cell_a (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_a),
      .d_i     ((i == 0) ? delta : swin_a[(i == 0) ? 0 : i-1]),
      .q_o     (swin_a[i])
    );
    hcc_step_cell u_cell_b (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_b),
      .d_i     ((i == 0) ? delta : swin_b[(i == 0) ? 0 : i-1]),
      .q_o     (swin_b[i])
    );
  end

  // running sums; the tail cell is the entry that leaves the window
  logic signed [SSUM_W-1:0] delta_x, tail_a_x, tail_b_x, ssum_a_d, ssum_b_d, lim;
  logic [DSUM_W-1:0]        dsum_a_d, dsum_b_d;
  logic                     win_ok;
  logic [RUN_W-1:0]         run_d;

  assign delta_x  = {{(SSUM_W-STEP_W){delta[STEP_W-1]}}, delta};
  assign tail_a_x = {{(SSUM_W-STEP_W){swin_a[STEP_WINDOW-1][STEP_W-1]}},
                     swin_a[STEP_WINDOW-1]};
  assign tail_b_x = {{(SSUM_W-STEP_W){swin_b[STEP_WINDOW-1][STEP_W-1]}},
                     swin_b[STEP_WINDOW-1]};
  assign ssum_a_d = turn_b_q ? ssum_a_q : ssum_a_q - tail_a_x + delta_x;
  assign ssum_b_d = turn_b_q ? ssum_b_q - tail_b_x + delta_x : ssum_b_q;
  assign lim      = {{(SSUM_W-DUTY_W-1){1'b0}}, step_size_q, 1'b0};
  assign win_ok   = (ssum_a_d >= -lim) && (ssum_a_d <= lim) &&
                    (ssum_b_d >= -lim) && (ssum_b_d <= lim);

  always_comb begin
    if (!win_ok) begin
      run_d = '0;
    end else if (run_q < RUN_LEN) begin
      run_d = run_q + RUN_W'(1);
    end else begin
      run_d = run_q;
    end
  end

  assign dsum_a_d = dsum_a_q - {{(DSUM_W-DUTY_W){1'b0}}, dwin[DUTY_WINDOW-1].a}
                  + {{(DSUM_W-DUTY_W){1'b0}}, duty_a_nxt};
  assign dsum_b_d = dsum_b_q - {{(DSUM_W-DUTY_W){1'b0}}, dwin[DUTY_WINDOW-1].b}
                  + {{(DSUM_W-DUTY_W){1'b0}}, duty_b_nxt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_a_q     <= '0;
      duty_b_q     <= '0;
      dir_a_q      <= 1'b0;
      dir_b_q      <= 1'b0;
      turn_b_q     <= 1'b0;
      last_power_q <= '0;
      ssum_a_q     <= SSUM_INIT;
      ssum_b_q     <= SSUM_INIT;
      dsum_a_q     <= '0;
      dsum_b_q     <= '0;
      run_q        <= '0;
      locked_q     <= 1'b0;
    end else if (climb) begin
      duty_a_q     <= duty_a_nxt;
      duty_b_q     <= duty_b_nxt;
      // a drop in power flips the idle channel's direction
      if (fell && !turn_b_q) dir_b_q <= !dir_b_q;
      if (fell && turn_b_q)  dir_a_q <= !dir_a_q;
      turn_b_q     <= !turn_b_q;
      last_power_q <= power_avg_i;
      ssum_a_q     <= ssum_a_d;
      ssum_b_q     <= ssum_b_d;
      dsum_a_q     <= dsum_a_d;
      dsum_b_q     <= dsum_b_d;
      run_q        <= run_d;
      if (run_d >= RUN_LEN) locked_q <= 1'b1;
    end else if (hold) begin
      duty_a_q <= quot_a_q;
      duty_b_q <= quot_b_q;
    end
  end

  // window averages; registered, valid in the cycle after the sums last moved
  logic [PROD_W-1:0] prod_a, prod_b;

  assign prod_a = {{RECIP_W{1'b0}}, dsum_a_q} * {{DSUM_W{1'b0}}, RECIP_C};
  assign prod_b = {{RECIP_W{1'b0}}, dsum_b_q} * {{DSUM_W{1'b0}}, RECIP_C};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_ok_q <= 1'b1;
    end else begin
      quot_ok_q <= !climb;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_a_q <= prod_a[RECIP_SHIFT +: DUTY_W];
    quot_b_q <= prod_b[RECIP_SHIFT +: DUTY_W];
  end

  // output stage: the state registers act as stage one
  logic [DUTY_W+CMP_W-1:0] cmp_prod_a, cmp_prod_b;

  assign cmp_prod_a = {{CMP_W{1'b0}}, duty_a_q} * {{DUTY_W{1'b0}}, carrier_q};
  assign cmp_prod_b = {{CMP_W{1'b0}}, duty_b_q} * {{DUTY_W{1'b0}}, carrier_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
        s1_valid_q  <= in_fire;
      end else if (in_fire) begin
        s1_valid_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      compare_a_o  <= cmp_prod_a[2*CMP_W-1:CMP_W];
      compare_b_o  <= cmp_prod_b[2*CMP_W-1:CMP_W];
      duty_a_out_o <= duty_a_q;
      duty_b_out_o <= duty_b_q;
      locked_o     <= locked_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/hcc_duty_cell.sv =====
// ----------------------------------------------------------------------------
// hcc_duty_cell
// One slot of the duty window shift line: holds a duty pair, shifts on enable.
// ----------------------------------------------------------------------------
module hcc_duty_cell
  import hcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  duty_pair_t d_i,
  output duty_pair_t q_o
);

  duty_pair_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= d_i;
    end
  end

  assign q_o = slot_q;

endmodule

// ===== rtl/hcc_step_cell.sv =====
// ----------------------------------------------------------------------------
// hcc_step_cell
// One slot of a step window shift line: holds a signed step, shifts on enable.
// ----------------------------------------------------------------------------
module hcc_step_cell
  import hcc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic signed [STEP_W-1:0] d_i,
  output logic signed [STEP_W-1:0] q_o
);

  logic signed [STEP_W-1:0] slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= STEP_INIT;
    end else if (shift_i) begin
      slot_q <= d_i;
    end
  end

  assign q_o = slot_q;

endmodule

// ===== rtl/hcc_checker.sv =====
// ----------------------------------------------------------------------------
// hcc_checker
// Port-level checks of the tracker core, bound to the core module.
// ----------------------------------------------------------------------------
module hcc_checker
  import hcc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [CMP_W-1:0]    compare_a_o,
  input logic [CMP_W-1:0]    compare_b_o,
  input logic [DUTY_W-1:0]   duty_a_out_o,
  input logic [DUTY_W-1:0]   duty_b_out_o,
  input logic                locked_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_a_out_o) &&
    $stable(duty_b_out_o) && $stable(compare_a_o) && $stable(locked_o))
    else $error("output transaction changed while stalled");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_a_out_o <= Q16_ONE && duty_b_out_o <= Q16_ONE)
    else $error("duty out of Q16 range");

  a_zero_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duty_a_out_o == '0 && duty_b_out_o == '0 |->
    compare_a_o == '0 && compare_b_o == '0)
    else $error("nonzero compare from zero duty");

  // lock is sticky until reset
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && locked_o |=> !out_valid_o || locked_o)
    else $error("lock dropped");

endmodule

bind dual_duty_hill_climb_tracker_core hcc_checker u_hcc_checker (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual duty hill climb tracker. A directed table
// covers reset values, duty clamping, wide steps, power extremes, compare
// scaling at carrier 0/1/65535, a disabled tick and an unused register index.
// Random phases then drive modeled power curves, ramps and noise under random
// settings, with idles and output stalls. A final phase locks the tracker and
// exercises it there. Results are checked against pinned rows or a predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hcc_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_NONE = 2'd3;  // decodes to nothing
  localparam int unsigned STEER_RUN = 25;
  localparam int unsigned RANDOM_TICKS = 1050;

  typedef struct packed {
    logic [CMP_W-1:0]  cmp_a;
    logic [CMP_W-1:0]  cmp_b;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic              locked;
  } tick_result_t;

  typedef enum bit {ROW_CFG, ROW_TICK} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CIDX_W-1:0]  idx;
    logic [CFG_W-1:0]   data;
    logic [POWER_W-1:0] power;
    bit                 pinned;
    tick_result_t       want;
  } plan_row_t;

  typedef enum logic [1:0] {PWR_HILL, PWR_RAMP, PWR_NOISE} power_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CIDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [POWER_W-1:0] power_avg_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CMP_W-1:0]   compare_a_o;
  logic [CMP_W-1:0]   compare_b_o;
  logic [DUTY_W-1:0]  duty_a_out_o;
  logic [DUTY_W-1:0]  duty_b_out_o;
  logic               locked_o;

  dual_duty_hill_climb_tracker_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .power_avg_i  (power_avg_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .compare_a_o  (compare_a_o),
    .compare_b_o  (compare_b_o),
    .duty_a_out_o (duty_a_out_o),
    .duty_b_out_o (duty_b_out_o),
    .locked_o     (locked_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // tracker predictor state
  bit                 trk_enable;
  logic [CMP_W-1:0]   trk_carrier;
  logic [CFG_W-1:0]   trk_step;
  logic [DUTY_W-1:0]  trk_duty_a, trk_duty_b;
  bit                 trk_dn_a, trk_dn_b, trk_turn_b, trk_locked;
  logic [POWER_W-1:0] trk_last;
  int                 trk_swin_a [STEP_WINDOW];
  int                 trk_swin_b [STEP_WINDOW];
  int unsigned        trk_sptr_a, trk_sptr_b;
  logic [DUTY_W-1:0]  trk_dwin_a [DUTY_WINDOW];
  logic [DUTY_W-1:0]  trk_dwin_b [DUTY_WINDOW];
  int unsigned        trk_dptr, trk_sum_a, trk_sum_b, trk_run;

  tick_result_t expected_ticks[$];
  int unsigned  errors;
  int unsigned  n_ticks;
  plan_row_t    plan[$];

  // stimulus shaping
  bit           rush;       // no idling on either side
  bit           steer;      // keep the tracker from locking
  power_mode_e  pmode;
  int unsigned  peak_a, peak_b, noise_amp;
  bit           pin_on;
  tick_result_t pin_res;

  function automatic logic [DUTY_W-1:0] nudge(input logic [DUTY_W-1:0] duty, input int delta);
    longint v;
    v = longint'(duty) + longint'(delta);
    if (v > longint'(Q16_ONE)) v = longint'(Q16_ONE);
    if (v < 0) v = 0;
    return DUTY_W'(v);
  endfunction

  function automatic logic [CMP_W-1:0] scale(input logic [DUTY_W-1:0] duty);
    longint unsigned p;
    p = longint'(duty) * longint'(trk_carrier);
    return CMP_W'(p >> 16);
  endfunction

  function automatic void apply_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    case (idx)
      CFG_ENABLE:  trk_enable = d[0];
      CFG_CARRIER: trk_carrier = d[CMP_W-1:0];
      CFG_STEP:    trk_step = d;
      default: ;
    endcase
  endfunction

  function automatic tick_result_t track_tick(input logic [POWER_W-1:0] p);
    tick_result_t r;
    bit           fell;
    int           st, d;
    longint       lim, sa, sb;
    if (trk_enable) begin
      if (trk_locked) begin
        trk_duty_a = DUTY_W'(trk_sum_a / DUTY_WINDOW);
        trk_duty_b = DUTY_W'(trk_sum_b / DUTY_WINDOW);
      end else begin
        fell = p < trk_last;
        st = int'(trk_step);
        lim = 2 * longint'(trk_step);
        if (!trk_turn_b) begin
          if (fell) trk_dn_b = !trk_dn_b;
          d = trk_dn_a ? -st : st;
          trk_duty_a = nudge(trk_duty_a, d);
          trk_swin_a[trk_sptr_a] = d;
          trk_sptr_a = (trk_sptr_a + 1) % STEP_WINDOW;
        end else begin
          if (fell) trk_dn_a = !trk_dn_a;
          d = trk_dn_b ? -st : st;
          trk_duty_b = nudge(trk_duty_b, d);
          trk_swin_b[trk_sptr_b] = d;
          trk_sptr_b = (trk_sptr_b + 1) % STEP_WINDOW;
        end
        trk_turn_b = !trk_turn_b;
        trk_sum_a = trk_sum_a - trk_dwin_a[trk_dptr] + trk_duty_a;
        trk_sum_b = trk_sum_b - trk_dwin_b[trk_dptr] + trk_duty_b;
        trk_dwin_a[trk_dptr] = trk_duty_a;
        trk_dwin_b[trk_dptr] = trk_duty_b;
        trk_dptr = (trk_dptr + 1) % DUTY_WINDOW;
        trk_last = p;
        sa = 0;
        sb = 0;
        for (int i = 0; i < STEP_WINDOW; i++) begin
          sa += trk_swin_a[i];
          sb += trk_swin_b[i];
        end
        if (sa >= -lim && sa <= lim && sb >= -lim && sb <= lim) begin
          if (trk_run < STABLE_RUN_LEN) trk_run++;
        end else begin
          trk_run = 0;
        end
        if (trk_run >= STABLE_RUN_LEN) trk_locked = 1'b1;
      end
    end
    r.cmp_a  = scale(trk_duty_a);
    r.cmp_b  = scale(trk_duty_b);
    r.duty_a = trk_duty_a;
    r.duty_b = trk_duty_b;
    r.locked = trk_locked;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned e,
                             input longint unsigned g);
    if (e != g) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, e, g);
    end
  endtask

  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_ticks.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction outstanding, expected none, got %0d/%0d",
                   $time, duty_a_out_o, duty_b_out_o);
        end else begin
          want = expected_ticks.pop_front();
          check_field("compare_a", want.cmp_a, compare_a_o);
          check_field("compare_b", want.cmp_b, compare_b_o);
          check_field("duty_a_out", want.duty_a, duty_a_out_o);
          check_field("duty_b_out", want.duty_b, duty_b_out_o);
          check_field("locked", want.locked, locked_o);
        end
      end
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_o) begin
        want = track_tick(power_avg_i);
        expected_ticks.push_back(pin_on ? pin_res : want);
      end
    end
  end

  function automatic int idle_len();
    int r;
    if (rush) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  initial begin : ready_gen
    int run;
    @(posedge rst_ni);
    forever begin
      run = rush ? 50 : $urandom_range(1, 12);
      @(negedge clk_i) out_ready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      run = idle_len();
      if (run > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (run - 1) @(negedge clk_i);
      end
    end
  end

  function automatic logic [POWER_W-1:0] next_power();
    longint da, db, v;
    int     r, d;
    // equal power holds both directions, so the step windows fill one-sided
    if (steer && trk_run >= STEER_RUN) return trk_last;
    case (pmode)
      PWR_HILL: begin
        da = (longint'(trk_duty_a) - longint'(peak_a)) / 16;
        db = (longint'(trk_duty_b) - longint'(peak_b)) / 16;
        v = longint'(32'h8000_0000) - da * da - db * db
            + longint'($urandom_range(0, noise_amp));
      end
      PWR_RAMP: begin
        r = $urandom_range(0, 99);
        d = $urandom_range(1, 5000);
        if (r < 60) v = longint'(trk_last) + d;
        else if (r < 80) v = longint'(trk_last);
        else v = longint'(trk_last) - d;
        if (v < 0) v = 0;
        if (v > longint'(32'hFFFF_FFFF)) v = longint'(32'hFFFF_FFFF);
      end
      default: v = longint'($urandom);
    endcase
    return POWER_W'(v);
  endfunction

  task automatic send_tick(input bit fixed, input logic [POWER_W-1:0] fixed_power,
                           input bit pinned, input tick_result_t want);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pin_on = pinned;
    pin_res = want;
    power_avg_i <= fixed ? fixed_power : next_power();
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    n_ticks++;
  endtask

  task automatic send_random();
    send_tick(1'b0, '0, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stop sending and wait until every outstanding result has drained
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic void add_cfg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = d;
    row.power = '0;
    row.pinned = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_tick(input logic [POWER_W-1:0] p, input bit pinned,
                                   input int unsigned ca, input int unsigned cb,
                                   input int unsigned da, input int unsigned db);
    plan_row_t row;
    row.kind = ROW_TICK;
    row.idx = '0;
    row.data = '0;
    row.power = p;
    row.pinned = pinned;
    row.want.cmp_a = CMP_W'(ca);
    row.want.cmp_b = CMP_W'(cb);
    row.want.duty_a = DUTY_W'(da);
    row.want.duty_b = DUTY_W'(db);
    row.want.locked = 1'b0;
    plan.push_back(row);
  endfunction

  task automatic random_config();
    logic [CFG_W-1:0] d;
    int r;
    if ($urandom_range(0, 9) != 0) begin
      d = CFG_W'($urandom);
      d[0] = ($urandom_range(0, 99) < 85);
      write_reg(CFG_ENABLE, d);
    end
    if ($urandom_range(0, 9) < 7) begin
      d = CFG_W'($urandom);
      r = $urandom_range(0, 9);
      d[CMP_W-1:0] = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'hFFFF :
                     CMP_W'($urandom_range(1, 65535));
      write_reg(CFG_CARRIER, d);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      d = (r == 0) ? CFG_W'(1) : (r == 1) ? CFG_W'(65536) : (r == 2) ? CFG_W'(131071) :
          CFG_W'($urandom_range(1, 8000));
      write_reg(CFG_STEP, d);
    end
    if ($urandom_range(0, 19) < 3) write_reg(CFG_NONE, CFG_W'($urandom));
  endtask

  task automatic new_curve();
    peak_a = $urandom_range(0, 65536);
    peak_b = $urandom_range(0, 65536);
    noise_amp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 200000);
  endtask

  initial begin : stimulus
    int r, len;
    trk_enable = 1'b0;
    trk_carrier = 16'd500;
    trk_step = 17'd3277;
    trk_duty_a = '0;
    trk_duty_b = '0;
    trk_dn_a = 1'b0;
    trk_dn_b = 1'b0;
    trk_turn_b = 1'b0;
    trk_locked = 1'b0;
    trk_last = '0;
    trk_sptr_a = 0;
    trk_sptr_b = 0;
    trk_dptr = 0;
    trk_sum_a = 0;
    trk_sum_b = 0;
    trk_run = 0;
    foreach (trk_swin_a[i]) begin
      trk_swin_a[i] = STEP_INIT_I;
      trk_swin_b[i] = STEP_INIT_I;
    end
    foreach (trk_dwin_a[i]) begin
      trk_dwin_a[i] = '0;
      trk_dwin_b[i] = '0;
    end
    errors = 0;
    n_ticks = 0;
    rush = 1'b0;
    steer = 1'b1;
    pmode = PWR_NOISE;
    pin_on = 1'b0;
    pin_res = '0;
    new_curve();

    // directed table: disabled after reset, then walk both channels into the rails
    add_tick(32'h1234_5678, 1, 0, 0, 0, 0);
    add_cfg(CFG_ENABLE, CFG_W'(1));
    add_tick(32'h0, 1, 25, 0, 3277, 0);
    add_tick(32'h0, 1, 25, 25, 3277, 3277);
    add_cfg(CFG_CARRIER, CFG_W'(65535));
    add_tick(32'hFFFF_FFFF, 1, 6553, 3276, 6554, 3277);
    add_tick(32'h0, 1, 6553, 6553, 6554, 6554);      // drop turns channel one down
    add_cfg(CFG_STEP, CFG_W'(65536));
    add_tick(32'h0, 1, 0, 6553, 0, 6554);            // clamp at zero
    add_tick(32'd5, 1, 0, 65535, 0, 65536);          // clamp at full scale
    add_cfg(CFG_STEP, CFG_W'(131071));
    add_tick(32'd4, 1, 0, 65535, 0, 65536);
    add_tick(32'd3, 1, 0, 0, 0, 0);
    add_tick(32'd3, 1, 65535, 0, 65536, 0);
    add_cfg(CFG_CARRIER, CFG_W'(0));
    add_tick(32'd9, 1, 0, 0, 65536, 0);
    add_cfg(CFG_CARRIER, CFG_W'(1));
    add_cfg(CFG_NONE, CFG_W'(0));
    add_tick(32'd7, 0, 0, 0, 0, 0);
    add_cfg(CFG_ENABLE, CFG_W'(17'h1FFFE));          // bit 0 clear: frozen
    add_tick(32'h0, 0, 0, 0, 0, 0);
    add_tick(32'h8000_0000, 0, 0, 0, 0, 0);
    add_cfg(CFG_ENABLE, CFG_W'(1));
    add_cfg(CFG_STEP, CFG_W'(0));
    add_tick(32'hAAAA_AAAA, 0, 0, 0, 0, 0);
    add_tick(32'h5555_5555, 0, 0, 0, 0, 0);
    add_cfg(CFG_STEP, CFG_W'(1));
    add_cfg(CFG_CARRIER, CFG_W'(500));
    add_tick(32'h5555_5555, 0, 0, 0, 0, 0);
    add_tick(32'h0000_FFFF, 0, 0, 0, 0, 0);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(1'b1, plan[i].power, plan[i].pinned, plan[i].want);
      end
    end

    // random phases, kept short of lock
    while (n_ticks < RANDOM_TICKS) begin
      settle();
      random_config();
      rush = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      pmode = (r < 55) ? PWR_HILL : (r < 75) ? PWR_RAMP : PWR_NOISE;
      new_curve();
      len = $urandom_range(20, 100);
      repeat (len) send_random();
    end

    // final phase: climb to lock, falling back to a zero step if needed
    settle();
    rush = 1'b0;
    steer = 1'b0;
    write_reg(CFG_ENABLE, CFG_W'(1));
    write_reg(CFG_STEP, CFG_W'($urandom_range(1, 2000)));
    pmode = PWR_HILL;
    new_curve();
    noise_amp = 0;
    for (int k = 0; k < 200 && !trk_locked; k++) send_random();
    if (!trk_locked) begin
      settle();
      write_reg(CFG_STEP, CFG_W'(0));
      while (!trk_locked) send_random();
    end
    pmode = PWR_NOISE;
    repeat (40) send_random();
    settle();
    write_reg(CFG_CARRIER, CFG_W'(65535));
    write_reg(CFG_ENABLE, CFG_W'(2));
    repeat (15) send_random();
    settle();
    write_reg(CFG_ENABLE, CFG_W'(1));
    write_reg(CFG_STEP, CFG_W'($urandom));
    write_reg(CFG_CARRIER, CFG_W'($urandom_range(1, 65535)));
    rush = 1'b1;
    repeat (60) send_random();
    rush = 1'b0;
    repeat (20) send_random();

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
